// File: hdl/srw_pkg.sv
// shared types and constants of the sequence reorder window
package srw_pkg;

	// field widths
	localparam int unsigned GROUP_W  = 64;
	localparam int unsigned SEQ_W    = 64;
	localparam int unsigned SIZE_W   = 27;
	localparam int unsigned HANDLE_W = 32;
	localparam int unsigned STAT_W   = 3;

	// largest window the slot logic is built for
	localparam int unsigned WINDOW_MAX = 256;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = SIZE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_ORDERED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUDGET  = 1'd1;

	// reset value of the byte budget: 64 MiB
	localparam logic [SIZE_W-1:0] BUDGET_RESET = SIZE_W'(64 * 1024 * 1024);

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
	localparam logic [STAT_W-1:0] STAT_STALE  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_GROUP  = 3'd2;
	localparam logic [STAT_W-1:0] STAT_WINDOW = 3'd3;
	localparam logic [STAT_W-1:0] STAT_BUDGET = 3'd4;

	// descriptor item
	typedef struct packed {
		logic [GROUP_W-1:0]  group_tag;
		logic [SEQ_W-1:0]    seq_id;
		logic [SIZE_W-1:0]   object_size;
		logic [HANDLE_W-1:0] payload_handle;
	} srw_desc_t;

	// result item
	typedef struct packed {
		logic [STAT_W-1:0]   status;
		logic                released;
		logic [SEQ_W-1:0]    rel_seq_id;
		logic [SIZE_W-1:0]   rel_size;
		logic [HANDLE_W-1:0] rel_handle;
		logic                last;
	} srw_result_t;

	// slot memory word
	typedef struct packed {
		logic [SIZE_W-1:0]   size;
		logic [HANDLE_W-1:0] handle;
	} srw_slot_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PREP,
		ST_DRAIN
	} srw_state_t;

endpackage

// File: hdl/srw_if.sv
// valid/ready channel interfaces for descriptor and result items
interface srw_desc_if import srw_pkg::*; ();
	logic      valid;
	logic      ready;
	srw_desc_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface srw_result_if import srw_pkg::*; ();
	logic        valid;
	logic        ready;
	srw_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/srw_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
module srw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/sequence_reorder_window_top.sv
// top level of the sequence reorder window: checks, slot store and in-order drain, or pass-through when not ordered
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+----------------------------------------------
//   desc     | in  | valid / ready  | group_tag, seq_id, object_size, payload_handle
//   result   | out | valid / ready  | status, released, rel_seq_id, rel_size,
//            |     |                | rel_handle, last
//   cfg      | in  | cfg_we         | cfg_idx, cfg_data (ordered_mode, byte_budget)
//
// an item that gives one result is accepted, then checked and stored
// an item that releases n descriptors is accepted, checked and stored, then a
// prep state primes the first slot ram read; each release is one slot ram read
// desc is ready only in idle; a stalled result holds the drain in place
// reset clears the valid bits of all slots at once, there is no clearing pass
// slot index tracks next_expected mod WINDOW incrementally, so a window that is
// not a power of two stays exact until the 64-bit sequence counter wraps
module sequence_reorder_window_top import srw_pkg::*; #(
	parameter int unsigned WINDOW = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	srw_desc_if.sink              desc,
	srw_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	// configuration registers
	logic              ordered_q;
	logic [SIZE_W-1:0] budget_q;

	// reorder state
	srw_state_t         state_q, state_d;
	logic               locked_q, locked_d;
	logic [GROUP_W-1:0] group_q, group_d;
	logic [SEQ_W-1:0]   ne_q, ne_d;
	logic [IW-1:0]      ne_slot_q, ne_slot_d;
	logic [SIZE_W-1:0]  held_q, held_d;
	logic [WINDOW-1:0]  slot_valid_q, slot_valid_d;

	// captured item and output register
	srw_desc_t   in_q;
	srw_result_t out_q, out_d;
	logic        out_valid_q;
	logic        out_load;
	logic        out_free;

	// check datapath
	logic [SEQ_W:0]    diff;
	logic              grp_ok;
	logic              stale;
	logic              beyond;
	logic [SIZE_W-1:0] avail;
	logic              over;
	logic [IW:0]       slot_sum;
	logic [IW-1:0]     slot_idx;
	logic              dup;
	logic              do_store;
	logic              drain_now;
	logic [STAT_W-1:0] chk_status;

	// drain datapath
	logic [IW-1:0]     nxt_slot;
	logic              rel_last;
	logic [SIZE_W-1:0] held_sub;

	// slot memory port
	logic      ram_we;
	srw_slot_t ram_wdata;
	srw_slot_t ram_rdata;

	assign out_free     = !out_valid_q || result.ready;
	assign desc.ready   = (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ordered_q <= 1'b1;
			budget_q  <= BUDGET_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ORDERED: ordered_q <= cfg_data[0];
				CFG_BUDGET:  budget_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	// classification of the captured item
	always_comb begin
		grp_ok   = !locked_q || (in_q.group_tag == group_q);
		diff     = {1'b0, in_q.seq_id} - {1'b0, ne_q};
		stale    = diff[SEQ_W];
		beyond   = (diff[SEQ_W-1:0] >= SEQ_W'(WINDOW));
		avail    = (budget_q > held_q) ? (budget_q - held_q) : '0;
		over     = (in_q.object_size > avail);
		slot_sum = {1'b0, ne_slot_q} + {1'b0, diff[IW-1:0]};
		if (slot_sum >= (IW+1)'(WINDOW)) begin
			slot_sum = slot_sum - (IW+1)'(WINDOW);
		end
		slot_idx = slot_sum[IW-1:0];
		dup      = slot_valid_q[slot_idx];

		if (!grp_ok) begin
			chk_status = STAT_GROUP;
		end else if (stale) begin
			chk_status = STAT_STALE;
		end else if (beyond) begin
			chk_status = STAT_WINDOW;
		end else if (over) begin
			chk_status = STAT_BUDGET;
		end else if (dup) begin
			chk_status = STAT_STALE;
		end else begin
			chk_status = STAT_OK;
		end

		do_store  = (chk_status == STAT_OK) && !dup;
		// nothing before next_expected is ever held, so only its own id starts a drain
		drain_now = do_store && (slot_idx == ne_slot_q);
	end

	// drain helpers
	always_comb begin
		nxt_slot = (ne_slot_q == IW'(WINDOW - 1)) ? '0 : ne_slot_q + 1'b1;
		rel_last = !slot_valid_q[nxt_slot];
		held_sub = (held_q >= ram_rdata.size) ? (held_q - ram_rdata.size) : '0;
	end

	assign ram_wdata.size   = in_q.object_size;
	assign ram_wdata.handle = in_q.payload_handle;

	// sequencer: next state and datapath controls
	always_comb begin
		state_d      = state_q;
		locked_d     = locked_q;
		group_d      = group_q;
		ne_d         = ne_q;
		ne_slot_d    = ne_slot_q;
		held_d       = held_q;
		slot_valid_d = slot_valid_q;
		out_load     = 1'b0;
		out_d        = '0;
		ram_we       = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (desc.valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!ordered_q) begin
					// pass-through
					if (out_free) begin
						out_load         = 1'b1;
						out_d.status     = STAT_OK;
						out_d.released   = 1'b1;
						out_d.rel_seq_id = in_q.seq_id;
						out_d.rel_size   = in_q.object_size;
						out_d.rel_handle = in_q.payload_handle;
						out_d.last       = 1'b1;
						state_d          = ST_IDLE;
					end
				end else if (drain_now || out_free) begin
					locked_d = 1'b1;
					if (!locked_q) begin
						group_d = in_q.group_tag;
					end
					if (do_store) begin
						ram_we                 = 1'b1;
						slot_valid_d[slot_idx] = 1'b1;
						held_d                 = held_q + in_q.object_size;
					end
					if (drain_now) begin
						state_d = ST_PREP;
					end else begin
						out_load     = 1'b1;
						out_d.status = chk_status;
						out_d.last   = 1'b1;
						state_d      = ST_IDLE;
					end
				end
			end
			ST_PREP: begin
				// read of the just written slot settles
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (out_free) begin
					out_load                = 1'b1;
					out_d.status            = STAT_OK;
					out_d.released          = 1'b1;
					out_d.rel_seq_id        = ne_q;
					out_d.rel_size          = ram_rdata.size;
					out_d.rel_handle        = ram_rdata.handle;
					out_d.last              = rel_last;
					slot_valid_d[ne_slot_q] = 1'b0;
					held_d                  = held_sub;
					ne_d                    = ne_q + 1'b1;
					ne_slot_d               = nxt_slot;
					if (rel_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			locked_q     <= 1'b0;
			group_q      <= '0;
			ne_q         <= '0;
			ne_slot_q    <= '0;
			held_q       <= '0;
			slot_valid_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			locked_q     <= locked_d;
			group_q      <= group_d;
			ne_q         <= ne_d;
			ne_slot_q    <= ne_slot_d;
			held_q       <= held_d;
			slot_valid_q <= slot_valid_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (desc.valid && desc.ready) begin
			in_q <= desc.data;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	// slot store; the read address follows the next value of the next_expected slot
	srw_ram #(
		.WIDTH($bits(srw_slot_t)),
		.DEPTH(WINDOW)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_idx),
		.wdata(ram_wdata),
		.raddr(ne_slot_d),
		.rdata(ram_rdata)
	);

	// the slot being drained always holds a descriptor
	a_drain_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> slot_valid_q[ne_slot_q])
		else $error("drain reached an empty slot");

	// each release advances the expected id by one
	a_release_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && out_free) |=> (ne_q == $past(ne_q) + 1'b1))
		else $error("release did not advance next_expected");

	// a result without a released descriptor is always the final one
	a_plain_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.released) |-> out_q.last)
		else $error("non-release result not marked last");

	// no new item is taken while an item still has results to give
	a_no_early_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.last) |-> !desc.ready)
		else $error("item accepted before previous results finished");

endmodule
